[src/pat_pkg.sv]
// Shared types, codes and constants of the peer address table.
`default_nettype none
package pat_pkg;

  localparam int TABLE_SLOTS_DEFAULT = 32;
  localparam int ADDR_W              = 48;
  localparam int COUNT_MAX           = 63;

  localparam logic [3:0] TRIES_MAX         = 4'd15;
  localparam logic [3:0] RETRY_LIMIT_RESET = 4'd3;

  localparam logic [1:0] OP_LOOKUP    = 2'd0;
  localparam logic [1:0] OP_MARK_DOWN = 2'd1;
  localparam logic [1:0] OP_MARK_UP   = 2'd2;
  localparam logic [1:0] OP_QUERY     = 2'd3;

  localparam logic [1:0] LIVE_INACTIVE    = 2'd0;
  localparam logic [1:0] LIVE_ACTIVE      = 2'd1;
  localparam logic [1:0] LIVE_UNREACHABLE = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] mac_address;
    logic [5:0]        slot_select;
  } req_t;

  typedef struct packed {
    logic [4:0] slot_index;
    logic       found;
    logic       added;
    logic       table_full;
    logic       index_error;
    logic [1:0] entry_status;
    logic [3:0] entry_tries;
    logic [5:0] device_count;
    logic [5:0] active_count;
  } rsp_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] tries;
  } live_t;

  typedef struct packed {
    logic done;
    logic found;
    logic added;
    logic full;
  } scan_res_t;

  typedef enum logic {
    SCAN_IDLE,
    SCAN_RUN
  } scan_state_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_SCAN,
    CTL_READ,
    CTL_COMMIT
  } ctl_state_t;

endpackage
`default_nettype wire

[src/peer_address_table.sv]
// Top level of the peer address table: request sequencer, liveness store and result register.
`default_nettype none
// Peer address table. A lookup-or-add request scans the filled slots one per cycle through a
// single 48-bit comparator on the address store's read port. A full table with no match skips
// the liveness read. Mark-unavailable, mark-available and query requests read the slot's
// liveness entry once, and skip that read when the slot number is out of range. One request
// is in progress at a time: req_stall stays high from acceptance until its result is loaded
// into the output register, which holds it until taken; a result still waiting there adds its
// stall cycles. The address store needs no clearing pass after reset, because slots are only
// ever filled in order behind a fill count. retry_limit is written through the cfg port,
// which is always ready, and is meant to change only while no request is in progress.
module peer_address_table #(
  parameter int TABLE_SLOTS = pat_pkg::TABLE_SLOTS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  pat_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output pat_pkg::rsp_t   rsp,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [3:0]      cfg_data
);
  import pat_pkg::*;

  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  ctl_state_t        state, state_next;
  logic [1:0]        op_q;
  logic [ADDR_W-1:0] mac_q;
  logic [SLOT_W-1:0] target_q;
  logic              found_q, added_q, full_q, ierr_q;
  logic [3:0]        retry_limit_q;
  logic [5:0]        active_q;
  logic [TABLE_SLOTS-1:0] live_vld;
  logic              rsp_valid_q;
  rsp_t              rsp_q;

  logic              accept, sel_bad, scan_start, live_rd_en, commit, live_wr;
  scan_res_t         scan_res;
  logic [SLOT_W-1:0] scan_slot;
  logic [5:0]        device_count;
  live_t             live_rd, cur, nxt;
  logic [5:0]        active_next;
  logic              blank;
  rsp_t              rsp_next;

  pat_scan #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (scan_start),
    .key         (mac_q),
    .res         (scan_res),
    .slot        (scan_slot),
    .device_count(device_count)
  );

  pat_ram #(
    .WIDTH($bits(live_t)),
    .DEPTH(TABLE_SLOTS)
  ) u_live_ram (
    .clk    (clk),
    .wr_en  (commit && live_wr),
    .wr_addr(target_q),
    .wr_data(nxt),
    .rd_en  (live_rd_en),
    .rd_addr(target_q),
    .rd_data(live_rd)
  );

  assign accept    = req_valid && !req_stall;
  assign sel_bad   = int'(req.slot_select) >= TABLE_SLOTS;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      CTL_IDLE: begin
        if (req_valid) begin
          if (req.op == OP_LOOKUP) begin
            state_next = CTL_SCAN;
          end else if (sel_bad) begin
            state_next = CTL_COMMIT;
          end else begin
            state_next = CTL_READ;
          end
        end
      end
      CTL_SCAN: begin
        if (scan_res.done) begin
          state_next = scan_res.full ? CTL_COMMIT : CTL_READ;
        end
      end
      CTL_READ:   state_next = CTL_COMMIT;
      CTL_COMMIT: begin
        if (commit) begin
          state_next = CTL_IDLE;
        end
      end
      default: state_next = CTL_IDLE;
    endcase
  end

  always_comb begin
    req_stall  = 1'b1;
    scan_start = 1'b0;
    live_rd_en = 1'b0;
    commit     = 1'b0;
    case (state)
      CTL_IDLE: begin
        req_stall  = 1'b0;
        scan_start = req_valid && (req.op == OP_LOOKUP);
      end
      CTL_READ:   live_rd_en = 1'b1;
      CTL_COMMIT: commit = !rsp_valid_q || !rsp_stall;
      default: ;
    endcase
  end

  // Apply the request to the slot's liveness entry; never-written entries read as reset.
  always_comb begin
    cur         = live_vld[target_q] ? live_rd : '0;
    nxt         = cur;
    active_next = active_q;
    live_wr     = 1'b0;
    blank       = ierr_q || full_q;
    if (!blank) begin
      case (op_q)
        OP_MARK_DOWN: begin
          live_wr   = 1'b1;
          nxt.tries = (cur.tries < TRIES_MAX) ? cur.tries + 4'd1 : cur.tries;
          nxt.status = (nxt.tries > retry_limit_q) ? LIVE_UNREACHABLE : LIVE_INACTIVE;
          if (cur.status == LIVE_ACTIVE && active_q != 6'd0) begin
            active_next = active_q - 6'd1;
          end
        end
        OP_MARK_UP: begin
          live_wr    = 1'b1;
          nxt.status = LIVE_ACTIVE;
          nxt.tries  = 4'd0;
          if (cur.status != LIVE_ACTIVE && active_q < 6'(COUNT_MAX)) begin
            active_next = active_q + 6'd1;
          end
        end
        OP_LOOKUP, OP_QUERY: ;
        default: ;
      endcase
    end
    rsp_next.slot_index   = blank ? 5'd0 : 5'(target_q);
    rsp_next.found        = found_q;
    rsp_next.added        = added_q;
    rsp_next.table_full   = full_q;
    rsp_next.index_error  = ierr_q;
    rsp_next.entry_status = blank ? LIVE_INACTIVE : nxt.status;
    rsp_next.entry_tries  = blank ? 4'd0 : nxt.tries;
    rsp_next.device_count = device_count;
    rsp_next.active_count = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= CTL_IDLE;
      retry_limit_q <= RETRY_LIMIT_RESET;
      active_q      <= '0;
      live_vld      <= '0;
      rsp_valid_q   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        retry_limit_q <= cfg_data;
      end
      if (commit) begin
        active_q <= active_next;
        if (live_wr) begin
          live_vld[target_q] <= 1'b1;
        end
      end
      if (commit) begin
        rsp_valid_q <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= req.op;
      mac_q    <= req.mac_address;
      target_q <= SLOT_W'(req.slot_select);
      ierr_q   <= (req.op != OP_LOOKUP) && sel_bad;
      found_q  <= 1'b0;
      added_q  <= 1'b0;
      full_q   <= 1'b0;
    end else if (state == CTL_SCAN && scan_res.done) begin
      target_q <= scan_slot;
      found_q  <= scan_res.found;
      added_q  <= scan_res.added;
      full_q   <= scan_res.full;
    end
    if (commit) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp_valid = rsp_valid_q;
  assign rsp       = rsp_q;

  a_active_bound: assert property (@(posedge clk) disable iff (rst)
    int'(active_q) <= TABLE_SLOTS)
    else $error("active count exceeds the number of slots");

  a_scan_done_owned: assert property (@(posedge clk) disable iff (rst)
    scan_res.done |-> (state == CTL_SCAN))
    else $error("scan finished outside a lookup request");

  a_live_write_mark: assert property (@(posedge clk) disable iff (rst)
    (commit && live_wr) |-> (!ierr_q && (op_q == OP_MARK_DOWN || op_q == OP_MARK_UP)))
    else $error("liveness written by a request that does not mark a slot");

endmodule
`default_nettype wire

[src/pat_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[src/pat_scan.sv]
// Address store and sequential lookup-or-add scan through one shared comparator.
`default_nettype none
module pat_scan #(
  parameter int TABLE_SLOTS = pat_pkg::TABLE_SLOTS_DEFAULT,
  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pat_pkg::ADDR_W-1:0] key,
  output pat_pkg::scan_res_t        res,
  output logic [SLOT_W-1:0]         slot,
  output logic [5:0]                device_count
);
  import pat_pkg::*;

  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(TABLE_SLOTS);

  scan_state_t       state, state_next;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  scan_idx;
  logic              data_vld;
  logic [SLOT_W-1:0] data_idx;
  logic [ADDR_W-1:0] rd_data;

  logic              done_q, found_q, added_q, full_q;
  logic [SLOT_W-1:0] slot_q;

  logic              hit, at_end, rd_en, wr_en, finish;
  logic              f_found, f_added, f_full;
  logic [SLOT_W-1:0] f_slot;

  // Slots below fill hold non-zero addresses; everything from fill upward is empty.
  pat_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(TABLE_SLOTS)
  ) u_addr_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(fill[SLOT_W-1:0]),
    .wr_data(key),
    .rd_en  (rd_en),
    .rd_addr(scan_idx[SLOT_W-1:0]),
    .rd_data(rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      SCAN_IDLE: begin
        if (start) begin
          state_next = SCAN_RUN;
        end
      end
      SCAN_RUN: begin
        if (finish) begin
          state_next = SCAN_IDLE;
        end
      end
      default: state_next = SCAN_IDLE;
    endcase
  end

  always_comb begin
    hit     = data_vld && (rd_data == key);
    at_end  = (scan_idx == fill);
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    finish  = 1'b0;
    f_found = 1'b0;
    f_added = 1'b0;
    f_full  = 1'b0;
    f_slot  = data_idx;
    case (state)
      SCAN_RUN: begin
        if (hit) begin
          finish  = 1'b1;
          f_found = 1'b1;
        end else if (at_end) begin
          finish = 1'b1;
          if (fill == FILL_MAX) begin
            f_full = 1'b1;
          end else begin
            // An all-zero key matches the first empty slot; nothing is written.
            f_slot = fill[SLOT_W-1:0];
            if (key == '0) begin
              f_found = 1'b1;
            end else begin
              f_added = 1'b1;
              wr_en   = 1'b1;
            end
          end
        end else begin
          rd_en = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= SCAN_IDLE;
      fill     <= '0;
      data_vld <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state    <= state_next;
      data_vld <= rd_en;
      done_q   <= finish;
      if (wr_en) begin
        fill <= fill + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      scan_idx <= '0;
    end else if (rd_en) begin
      scan_idx <= scan_idx + CNT_W'(1);
    end
    if (rd_en) begin
      data_idx <= scan_idx[SLOT_W-1:0];
    end
    if (finish) begin
      found_q <= f_found;
      added_q <= f_added;
      full_q  <= f_full;
      slot_q  <= f_slot;
    end
  end

  assign res.done  = done_q;
  assign res.found = found_q;
  assign res.added = added_q;
  assign res.full  = full_q;
  assign slot      = slot_q;
  assign device_count = (int'(fill) > COUNT_MAX) ? 6'(COUNT_MAX) : 6'(fill);

  a_read_in_fill: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (scan_idx < fill))
    else $error("scan read beyond the filled region");

  a_write_has_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (fill < FILL_MAX))
    else $error("address written into a full table");

  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    done_q |-> $onehot({found_q, added_q, full_q}))
    else $error("scan ended without exactly one outcome");

endmodule
`default_nettype wire

[verif/peer_address_table_tb.sv]
// Testbench of the peer address table: random and directed requests checked against a mirror.
module peer_address_table_tb;
  import pat_pkg::*;

  localparam int SLOTS         = TABLE_SLOTS_DEFAULT;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASE_ITEMS   = 380;

  // Mirror of the table contents; holds the responses still due, oldest first.
  class peer_table_mirror;
    logic [ADDR_W-1:0] macs [SLOTS];
    logic [1:0]        live [SLOTS];
    logic [3:0]        tries [SLOTS];
    int unsigned       registered;
    int unsigned       active;
    logic [3:0]        retry_limit;
    rsp_t              due_responses[$];
    int                errors;
    int                responses_seen;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        macs[i]  = '0;
        live[i]  = LIVE_INACTIVE;
        tries[i] = '0;
      end
      registered     = 0;
      active         = 0;
      retry_limit    = RETRY_LIMIT_RESET;
      errors         = 0;
      responses_seen = 0;
    endfunction

    function void set_retry_limit(logic [3:0] v);
      retry_limit = v;
    endfunction

    function int pending();
      return due_responses.size();
    endfunction

    function void report(string msg);
      errors++;
      $display("mismatch at response %0d: %s", responses_seen, msg);
    endfunction

    function void cmp(string what, logic [47:0] got, logic [47:0] want);
      if (got !== want) report($sformatf("%s got %0h, expected %0h", what, got, want));
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int   sel;
      e   = '0;
      sel = r.slot_select;
      if (r.op == OP_LOOKUP) begin
        e.table_full = 1'b1;
        // first match or first empty slot ends the scan
        for (int i = 0; i < SLOTS; i++) begin
          if (macs[i] == r.mac_address) begin
            e.found = 1'b1;
          end else if (macs[i] == '0) begin
            macs[i]    = r.mac_address;
            registered = (i + 1 > COUNT_MAX) ? COUNT_MAX : i + 1;
            e.added    = 1'b1;
          end else begin
            continue;
          end
          e.table_full   = 1'b0;
          e.slot_index   = 5'(i);
          e.entry_status = live[i];
          e.entry_tries  = tries[i];
          break;
        end
      end else if (sel >= SLOTS) begin
        e.index_error = 1'b1;
      end else begin
        e.slot_index = 5'(sel);
        if (r.op == OP_MARK_DOWN) begin
          if (live[sel] == LIVE_ACTIVE && active > 0) active--;
          live[sel] = LIVE_INACTIVE;
          if (tries[sel] < TRIES_MAX) tries[sel]++;
          if (tries[sel] > retry_limit) live[sel] = LIVE_UNREACHABLE;
        end else if (r.op == OP_MARK_UP) begin
          if (live[sel] != LIVE_ACTIVE && active < COUNT_MAX) active++;
          live[sel]  = LIVE_ACTIVE;
          tries[sel] = '0;
        end
        e.entry_status = live[sel];
        e.entry_tries  = tries[sel];
      end
      e.device_count = 6'(registered);
      e.active_count = 6'(active);
      due_responses.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      responses_seen++;
      if (due_responses.size() == 0) begin
        report("response with no request outstanding");
        return;
      end
      want = due_responses.pop_front();
      cmp("slot_index", got.slot_index, want.slot_index);
      cmp("found", got.found, want.found);
      cmp("added", got.added, want.added);
      cmp("table_full", got.table_full, want.table_full);
      cmp("index_error", got.index_error, want.index_error);
      cmp("entry_status", got.entry_status, want.entry_status);
      cmp("entry_tries", got.entry_tries, want.entry_tries);
      cmp("device_count", got.device_count, want.device_count);
      cmp("active_count", got.active_count, want.active_count);
    endfunction
  endclass

  logic       clk;
  logic       rst       = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  req_t       req       = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  rsp_t       rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data  = '0;

  bit                calm        = 1'b0;
  int                idle_cycles = 0;
  logic [ADDR_W-1:0] known_macs[$];
  peer_table_mirror  mirror      = new();

  peer_address_table #(.TABLE_SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0) mirror.check_response(rsp);
    rsp_stall <= !calm && ($urandom_range(99) < 34);
  end

  // Restart the count on any handshake; give up after a long silence.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[peer_address_table] ERROR");
      $finish;
    end
  end

  function automatic req_t make_req(logic [1:0] op, logic [ADDR_W-1:0] mac, logic [5:0] sel);
    req_t r;
    r.op          = op;
    r.mac_address = mac;
    r.slot_select = sel;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] random_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[ADDR_W-1:0];
  endfunction

  task automatic send_request(input req_t r);
    while (!calm && $urandom_range(99) < 34) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    mirror.note_request(r);
  endtask

  task automatic write_retry_limit(input logic [3:0] v);
    req_valid <= 1'b0;
    // drain every request before touching the limit
    while (mirror.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    mirror.set_retry_limit(v);
  endtask

  task automatic run_directed();
    send_request(make_req(OP_QUERY, random_mac(), 6'd0));
    // zero address matches the first empty slot and writes nothing
    send_request(make_req(OP_LOOKUP, '0, 6'd63));
    send_request(make_req(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 6'd0));
    send_request(make_req(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 6'd21));
    send_request(make_req(OP_LOOKUP, 48'hAAAA_AAAA_AAAA, 6'd42));
    send_request(make_req(OP_LOOKUP, 48'h5555_5555_5555, 6'd0));
    send_request(make_req(OP_LOOKUP, '0, 6'd0));
    send_request(make_req(OP_MARK_UP, random_mac(), 6'd0));
    send_request(make_req(OP_MARK_UP, random_mac(), 6'd0));
    repeat (5) send_request(make_req(OP_MARK_DOWN, random_mac(), 6'd0));
    send_request(make_req(OP_QUERY, random_mac(), 6'd0));
    send_request(make_req(OP_MARK_UP, random_mac(), 6'd0));
    // mark an empty slot, then fill up to it: its liveness stays
    send_request(make_req(OP_MARK_UP, random_mac(), 6'd5));
    send_request(make_req(OP_LOOKUP, 48'h0000_0000_0001, 6'd0));
    send_request(make_req(OP_LOOKUP, 48'h8000_0000_0000, 6'd0));
    send_request(make_req(OP_LOOKUP, 48'h1234_5678_9ABC, 6'd0));
    send_request(make_req(OP_MARK_DOWN, random_mac(), 6'd63));
    send_request(make_req(OP_MARK_UP, random_mac(), 6'd32));
    send_request(make_req(OP_QUERY, random_mac(), 6'd63));
    send_request(make_req(OP_QUERY, random_mac(), 6'd31));
    known_macs.push_back(48'hFFFF_FFFF_FFFF);
    known_macs.push_back(48'hAAAA_AAAA_AAAA);
    known_macs.push_back(48'h5555_5555_5555);
    known_macs.push_back(48'h0000_0000_0001);
    known_macs.push_back(48'h8000_0000_0000);
    known_macs.push_back(48'h1234_5678_9ABC);
  endtask

  task automatic run_random(input int n);
    int                sent;
    int                kind;
    int                len;
    int                pick;
    logic [5:0]        slot;
    logic [ADDR_W-1:0] mac;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        // burst of lookups, mostly of addresses seen before
        len = $urandom_range(1, 4);
        repeat (len) begin
          pick = $urandom_range(99);
          if (pick < 8) begin
            mac = random_mac();
            known_macs.push_back(mac);
          end else if (pick < 11) begin
            mac = '0;
          end else if (pick < 14) begin
            mac = ($urandom_range(1) != 0) ? 48'hFFFF_FFFF_FFFF : 48'h8000_0000_0001;
          end else begin
            mac = known_macs[$urandom_range(known_macs.size() - 1)];
          end
          send_request(make_req(OP_LOOKUP, mac, 6'($urandom_range(63))));
          sent++;
        end
      end else if (kind < 70) begin
        // run of failed contacts on one slot, closed by a recovery or a query
        slot = ($urandom_range(9) == 0) ? 6'($urandom_range(32, 63)) : 6'($urandom_range(0, 31));
        len  = $urandom_range(1, 18);
        repeat (len) begin
          send_request(make_req(OP_MARK_DOWN, random_mac(), slot));
          sent++;
        end
        send_request(make_req(($urandom_range(1) != 0) ? OP_MARK_UP : OP_QUERY,
                              random_mac(), slot));
        sent++;
      end else begin
        send_request(make_req(2'($urandom_range(3)), random_mac(), 6'($urandom_range(63))));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    write_retry_limit(4'd0);
    run_random(PHASE_ITEMS);
    calm <= 1'b1;
    write_retry_limit(4'd14);
    run_random(PHASE_ITEMS);
    calm <= 1'b0;
    write_retry_limit(4'd15);
    run_random(PHASE_ITEMS);
    write_retry_limit(4'd7);
    run_random(PHASE_ITEMS);
    write_retry_limit(4'($urandom_range(1, 13)));
    run_random(PHASE_ITEMS);
    req_valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending() == 0)
      $display("[peer_address_table] OK");
    else
      $display("[peer_address_table] ERROR");
    $finish;
  end

endmodule
